FILE: rtl/core/cbd_pkg.sv
// Shared beat types and character constants for the chunked body decoder.
`timescale 1ns / 1ps

package cbd_pkg;

    // One raw byte of the chunked body.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } body_beat_t;

    // One decoded data byte or one end-of-message status.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
    } result_beat_t;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam int          LIMIT_W     = 31;
    localparam int          HEX_BITS    = 4;
    localparam logic [7:0]  CHAR_CR     = 8'h0D;
    localparam logic [7:0]  CHAR_LF     = 8'h0A;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

endpackage

FILE: rtl/core/chunked_body_decoder.sv
// Chunked transfer body decoder: size lines, data pass-through and end status.
`timescale 1ns / 1ps
// The body channel (body_valid, body_stall, body_beat) carries one raw byte per beat,
// with in_last marking the final byte of a message. The result channel (res_valid,
// res_stall, res_beat) carries decoded data bytes (kind data) and, once per message,
// one status beat (ok or error). Size lines, CRLF markers and trailer bytes give no
// result beat. After an error the consumer should discard the data of that message.
// A byte accepted on the body channel is registered in the input register, decoded
// combinationally and its result is registered in the result register. One byte is
// taken every cycle while the receiver does not stall; the throughput is set by the
// single decode stage between the input register and the result register.
// When the receiver stalls, the result register holds its beat and the input
// register holds the next byte; body_stall rises only when both are full.
// chunk_limit_we writes the largest accepted chunk size; write it only while idle.
// Reset clears both registers, returns the parser to the start of a size line and
// restores the chunk limit to its largest value.
module chunked_body_decoder #(
    parameter int SIZE_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       body_valid,
    output logic                       body_stall,
    input  cbd_pkg::body_beat_t        body_beat,
    output logic                       res_valid,
    input  logic                       res_stall,
    output cbd_pkg::result_beat_t      res_beat,
    input  logic                       chunk_limit_we,
    input  logic [cbd_pkg::LIMIT_W-1:0] chunk_limit_data
);

    import cbd_pkg::*;

    localparam int NEXT_W = SIZE_WIDTH + HEX_BITS;
    localparam int CMP_W  = (NEXT_W > LIMIT_W) ? NEXT_W : LIMIT_W;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_DATA,
        PH_CR,
        PH_LF,
        PH_TRAILER
    } phase_t;

    logic                  s1_valid_reg, s1_valid_next;
    body_beat_t            s1_beat_reg;
    logic                  res_valid_reg, res_valid_next;
    result_beat_t          res_beat_reg, res_beat_next;
    logic [LIMIT_W-1:0]    limit_reg;

    phase_t                phase_reg, phase_next;
    logic [SIZE_WIDTH-1:0] accum_reg, accum_next;
    logic                  has_digit_reg, has_digit_next;
    logic                  cr_seen_reg, cr_seen_next;
    logic [SIZE_WIDTH-1:0] left_reg, left_next;
    logic                  settled_reg, settled_next;

    logic                  out_free;
    logic                  fire;
    logic                  emit;
    logic [1:0]            emit_kind;
    logic [7:0]            emit_byte;
    logic [7:0]            b;
    logic                  hex_ok;
    logic [HEX_BITS-1:0]   hex_digit;
    logic [NEXT_W-1:0]     size_shifted;
    logic                  size_too_big;
    logic [SIZE_WIDTH-1:0] left_dec;

    assign out_free   = !res_valid_reg || !res_stall;
    assign fire       = s1_valid_reg && out_free;
    assign body_stall = s1_valid_reg && !out_free;
    assign res_valid  = res_valid_reg;
    assign res_beat   = res_beat_reg;
    assign b          = s1_beat_reg.in_byte;

    always_comb
    begin
        hex_ok    = 1'b1;
        hex_digit = '0;
        if (b >= "0" && b <= "9")
        begin
            hex_digit = HEX_BITS'(b - 8'h30);
        end
        else if (b >= "a" && b <= "f")
        begin
            hex_digit = HEX_BITS'(b - 8'h57);
        end
        else if (b >= "A" && b <= "F")
        begin
            hex_digit = HEX_BITS'(b - 8'h37);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    // The new size is checked against both the limit and the accumulator range.
    assign size_shifted = {accum_reg, hex_digit};
    assign size_too_big = (CMP_W'(size_shifted) > CMP_W'(limit_reg))
                       || (size_shifted[NEXT_W-1:SIZE_WIDTH] != '0);
    assign left_dec     = (left_reg != '0) ? left_reg - 1'b1 : left_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        has_digit_next = has_digit_reg;
        cr_seen_next   = cr_seen_reg;
        left_next      = left_reg;
        settled_next   = settled_reg;
        emit           = 1'b0;
        emit_kind      = KIND_DATA;
        emit_byte      = '0;

        if (!settled_reg)
        begin
            case (phase_reg)
                PH_SIZE:
                begin
                    if (cr_seen_reg && b != CHAR_LF)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_ERR;
                    end
                    else if (b == CHAR_CR)
                    begin
                        cr_seen_next = 1'b1;
                    end
                    else if (b == CHAR_LF)
                    begin
                        if (has_digit_reg)
                        begin
                            if (accum_reg == '0)
                            begin
                                phase_next = PH_TRAILER;
                            end
                            else
                            begin
                                left_next  = accum_reg;
                                phase_next = PH_DATA;
                            end
                        end
                        accum_next     = '0;
                        has_digit_next = 1'b0;
                        cr_seen_next   = 1'b0;
                    end
                    else if (!hex_ok || size_too_big)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_ERR;
                    end
                    else
                    begin
                        accum_next     = size_shifted[SIZE_WIDTH-1:0];
                        has_digit_next = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_DATA;
                    emit_byte = b;
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        phase_next = PH_CR;
                    end
                end
                PH_CR:
                begin
                    if (b != CHAR_CR)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_ERR;
                    end
                    else
                    begin
                        phase_next = PH_LF;
                    end
                end
                PH_LF:
                begin
                    if (b != CHAR_LF)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_ERR;
                    end
                    else
                    begin
                        phase_next = PH_SIZE;
                    end
                end
                PH_TRAILER:
                begin
                    if (b == CHAR_LF)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_OK;
                    end
                end
                default:
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_ERR;
                end
            endcase
            if (emit && emit_kind != KIND_DATA)
            begin
                settled_next = 1'b1;
            end
        end

        if (s1_beat_reg.in_last)
        begin
            // The end status replaces a data beat, but never an earlier status.
            if (!settled_next)
            begin
                emit      = 1'b1;
                emit_byte = '0;
                if (phase_next == PH_SIZE)
                begin
                    emit_kind = (has_digit_next && accum_next != '0) ? KIND_ERR : KIND_OK;
                end
                else if (phase_next == PH_TRAILER)
                begin
                    emit_kind = KIND_OK;
                end
                else
                begin
                    emit_kind = KIND_ERR;
                end
            end
            phase_next     = PH_SIZE;
            accum_next     = '0;
            has_digit_next = 1'b0;
            cr_seen_next   = 1'b0;
            left_next      = '0;
            settled_next   = 1'b0;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (body_valid && !body_stall)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next         = res_valid_reg;
        res_beat_next          = res_beat_reg;
        if (fire && emit)
        begin
            res_valid_next         = 1'b1;
            res_beat_next.out_byte = emit_byte;
            res_beat_next.out_kind = emit_kind;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_beat_reg   <= '0;
            res_valid_reg <= 1'b0;
            res_beat_reg  <= '0;
            limit_reg     <= LIMIT_RESET;
            phase_reg     <= PH_SIZE;
            accum_reg     <= '0;
            has_digit_reg <= 1'b0;
            cr_seen_reg   <= 1'b0;
            left_reg      <= '0;
            settled_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            res_beat_reg  <= res_beat_next;
            if (body_valid && !body_stall)
            begin
                s1_beat_reg <= body_beat;
            end
            if (chunk_limit_we)
            begin
                limit_reg <= chunk_limit_data;
            end
            if (fire)
            begin
                phase_reg     <= phase_next;
                accum_reg     <= accum_next;
                has_digit_reg <= has_digit_next;
                cr_seen_reg   <= cr_seen_next;
                left_reg      <= left_next;
                settled_reg   <= settled_next;
            end
        end
    end

endmodule
